// File: rtl/core/cbpa_pkg.sv
// Shared types and codes for the checked block pointer allocator.
package cbpa_pkg;

  typedef enum logic [2:0] {
    MODE_ALLOCATE   = 3'd0,
    MODE_DEALLOCATE = 3'd1,
    MODE_REPLACE    = 3'd2,
    MODE_NULLIFY    = 3'd3,
    MODE_INIT       = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_INVALID = 2'd1,
    STATUS_TAKEN   = 2'd2
  } status_t;

  localparam int unsigned PTR_W   = 32;
  localparam int unsigned COUNT_W = 13;

  // Map port controls from the sequencer to the bitmap memory.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic wr_bit;
  } map_ctl_t;

endpackage

// File: rtl/core/cbpa_if.sv
// Request and response channel interfaces for the block pointer allocator.
interface cbpa_req_if
  import cbpa_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [2:0]         mode;
  logic [PTR_W-1:0]   old_pointer;
  logic [PTR_W-1:0]   new_pointer;
  logic [COUNT_W-1:0] reserved_count;

  modport source (output valid, mode, old_pointer, new_pointer, reserved_count,
                  input ready);
  modport sink   (input valid, mode, old_pointer, new_pointer, reserved_count,
                  output ready);
endinterface

interface cbpa_rsp_if
  import cbpa_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [PTR_W-1:0] pointer_out;

  modport source (output valid, status, pointer_out, input ready);
  modport sink   (input valid, status, pointer_out, output ready);
endinterface

// File: rtl/core/cbpa_map.sv
// One-bit-per-block allocation bitmap: one write port, one registered read port.
module cbpa_map
  import cbpa_pkg::*;
#(
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  map_ctl_t                 ctl,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  output logic                     rd_bit
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= ctl.wr_bit;
    end
    if (ctl.rd_en) begin
      rd_bit <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/checked_block_pointer_allocator_unit.sv
// Top level of the checked block pointer allocator: request checks and map sequencing.
//
//  channel | dir | beat contents                                      | handshake
//  --------+-----+----------------------------------------------------+-----------
//  req     | in  | mode, old_pointer, new_pointer, reserved_count     | valid/ready
//  rsp     | out | status, pointer_out                                | valid/ready
//
// Steps per request (map bitmap is a single-write-port memory with a registered read):
//   nullify, deallocate, rejected request: answered straight from idle
//   allocate: read the target bit, then set it
//   replace:  read, set new bit, clear old bit; no set or clear when the target is taken
//   init:     response at once, then a sweep with one map entry written per cycle
// After rst the map is cleared by the same sweep, with req.ready low throughout.
// req.ready also stays low while a finished response sits unclaimed on rsp.
module checked_block_pointer_allocator_unit
  import cbpa_pkg::*;
#(
  parameter int unsigned MAP_ENTRIES = 4096   // power of two, 16 .. 65536
) (
  input  logic           clk,
  input  logic           rst,
  cbpa_req_if.sink       req,
  cbpa_rsp_if.source     rsp
);

  localparam int unsigned IDX_W = $clog2(MAP_ENTRIES);
  localparam int unsigned CNT_W = IDX_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAP_ENTRIES - 1);

  typedef enum logic [1:0] {
    ST_SWEEP,   // writing every map entry (reset clear or init)
    ST_IDLE,    // waiting for a request
    ST_CHECK,   // target bit is back from the map
    ST_CLEAR    // replace: clear the old bit
  } state_t;

  state_t             state;
  logic [IDX_W-1:0]   sweep_idx;
  logic [CNT_W-1:0]   sweep_cnt;
  logic [PTR_W-1:0]   hold_old;
  logic [PTR_W-1:0]   hold_new;
  logic               hold_replace;
  logic               rsp_valid;
  logic [1:0]         rsp_status;
  logic [PTR_W-1:0]   rsp_pointer;

  logic               accept;
  logic               req_ok;
  logic               sweep_mark;
  logic               rd_bit;
  map_ctl_t           map_ctl;
  logic [IDX_W-1:0]   rd_addr;
  logic [IDX_W-1:0]   wr_addr;
  mode_t              req_mode;

  assign req_mode = mode_t'(req.mode);

  // Take a request only from idle and only with a free response slot.
  assign req.ready = (state == ST_IDLE) && (!rsp_valid || rsp.ready);
  assign accept    = req.valid && req.ready;

  assign rsp.valid       = rsp_valid;
  assign rsp.status      = rsp_status;
  assign rsp.pointer_out = rsp_pointer;

  // Mode rules. Region is the pointer above the map index bits.
  always_comb begin
    case (req_mode)
      MODE_ALLOCATE:   req_ok = (req.new_pointer != '0) &&
                                ((req.old_pointer == '0) ||
                                 (req.old_pointer == req.new_pointer));
      MODE_DEALLOCATE: req_ok = (req.new_pointer == '0) && (req.old_pointer != '0);
      MODE_REPLACE:    req_ok = (req.new_pointer != '0) && (req.old_pointer != '0) &&
                                (req.old_pointer[PTR_W-1:IDX_W] ==
                                 req.new_pointer[PTR_W-1:IDX_W]);
      default:         req_ok = 1'b0;
    endcase
  end

  assign sweep_mark = {1'b0, sweep_idx} < sweep_cnt;

  // Map port steering.
  always_comb begin
    map_ctl = '0;
    rd_addr = req.new_pointer[IDX_W-1:0];
    wr_addr = sweep_idx;
    case (state)
      ST_SWEEP: begin
        map_ctl.wr_en  = 1'b1;
        map_ctl.wr_bit = sweep_mark;
      end
      ST_IDLE: begin
        if (accept && req_ok) begin
          if (req_mode == MODE_DEALLOCATE) begin
            map_ctl.wr_en  = 1'b1;
            map_ctl.wr_bit = 1'b0;
            wr_addr        = req.old_pointer[IDX_W-1:0];
          end else begin
            map_ctl.rd_en = 1'b1;
          end
        end
      end
      ST_CHECK: begin
        if (!rd_bit) begin
          map_ctl.wr_en  = 1'b1;
          map_ctl.wr_bit = 1'b1;
          wr_addr        = hold_new[IDX_W-1:0];
        end
      end
      ST_CLEAR: begin
        // Equal pointers land on the same entry: set then clear leaves it free.
        map_ctl.wr_en  = 1'b1;
        map_ctl.wr_bit = 1'b0;
        wr_addr        = hold_old[IDX_W-1:0];
      end
      default: begin
        map_ctl = '0;
      end
    endcase
  end

  cbpa_map #(
    .DEPTH (MAP_ENTRIES)
  ) u_map (
    .clk     (clk),
    .ctl     (map_ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .rd_bit  (rd_bit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_SWEEP;
      sweep_idx <= '0;
      sweep_cnt <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // An accepted request loads rsp_valid itself below.
      if (rsp_valid && rsp.ready && !accept) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_SWEEP: begin
          if (sweep_idx == LAST_IDX) begin
            sweep_idx <= '0;
            state     <= ST_IDLE;
          end else begin
            sweep_idx <= sweep_idx + 1'b1;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            hold_old     <= req.old_pointer;
            hold_new     <= req.new_pointer;
            hold_replace <= (req_mode == MODE_REPLACE);
            if (req_mode == MODE_NULLIFY) begin
              rsp_valid   <= 1'b1;
              rsp_status  <= STATUS_OK;
              rsp_pointer <= '0;
            end else if (req_mode == MODE_INIT) begin
              // Response goes out now; the map sweep runs behind it.
              rsp_valid   <= 1'b1;
              rsp_status  <= STATUS_OK;
              rsp_pointer <= '0;
              sweep_idx   <= '0;
              state       <= ST_SWEEP;
              if (32'(req.reserved_count) > 32'(MAP_ENTRIES)) begin
                sweep_cnt <= CNT_W'(MAP_ENTRIES);
              end else begin
                sweep_cnt <= CNT_W'(req.reserved_count);
              end
            end else if (!req_ok) begin
              rsp_valid   <= 1'b1;
              rsp_status  <= STATUS_INVALID;
              rsp_pointer <= req.old_pointer;
            end else if (req_mode == MODE_DEALLOCATE) begin
              rsp_valid   <= 1'b1;
              rsp_status  <= STATUS_OK;
              rsp_pointer <= req.new_pointer;
            end else begin
              // any earlier beat was taken at this edge
              rsp_valid <= 1'b0;
              state     <= ST_CHECK;
            end
          end
        end
        ST_CHECK: begin
          if (rd_bit) begin
            rsp_valid   <= 1'b1;
            rsp_status  <= STATUS_TAKEN;
            rsp_pointer <= hold_old;
            state       <= ST_IDLE;
          end else if (hold_replace) begin
            state <= ST_CLEAR;
          end else begin
            rsp_valid   <= 1'b1;
            rsp_status  <= STATUS_OK;
            rsp_pointer <= hold_new;
            state       <= ST_IDLE;
          end
        end
        ST_CLEAR: begin
          rsp_valid   <= 1'b1;
          rsp_status  <= STATUS_OK;
          rsp_pointer <= hold_new;
          state       <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/cbpa_checker.sv
// Port-level checks for the block pointer allocator, bound to the top level.
module cbpa_checker
  import cbpa_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             req_valid,
  input logic             req_ready,
  input logic [2:0]       req_mode,
  input logic [PTR_W-1:0] req_old_pointer,
  input logic [PTR_W-1:0] req_new_pointer,
  input logic             rsp_valid,
  input logic             rsp_ready,
  input logic [1:0]       rsp_status,
  input logic [PTR_W-1:0] rsp_pointer_out
);

  // No response beat right after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  // Stalled response holds.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
                                $stable(rsp_pointer_out))
    else $error("stalled response changed");

  // Nullify answers in the next cycle with ok and a zero pointer.
  a_nullify: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_mode == MODE_NULLIFY |=>
      rsp_valid && rsp_status == STATUS_OK && rsp_pointer_out == '0)
    else $error("nullify response wrong");

  // A well-formed deallocate answers in the next cycle with ok and a zero pointer.
  a_dealloc: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_mode == MODE_DEALLOCATE &&
    req_new_pointer == '0 && req_old_pointer != '0 |=>
      rsp_valid && rsp_status == STATUS_OK && rsp_pointer_out == '0)
    else $error("deallocate response wrong");

  // Status code three is never produced.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_status != 2'd3)
    else $error("undefined status code");

endmodule

bind checked_block_pointer_allocator_unit cbpa_checker u_cbpa_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .req_mode        (req.mode),
  .req_old_pointer (req.old_pointer),
  .req_new_pointer (req.new_pointer),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_status      (rsp.status),
  .rsp_pointer_out (rsp.pointer_out)
);

// File: sim/checked_block_pointer_allocator_unit_tb.sv
// Testbench for checked_block_pointer_allocator_unit: directed table, then random requests.
`timescale 1ns / 1ps

module checked_block_pointer_allocator_unit_tb;
  import cbpa_pkg::*;

  localparam int unsigned MAP_ENTRIES  = 4096;
  localparam int unsigned RANDOM_ITEMS = 600;
  localparam int unsigned SLOTS        = 16;
  localparam int unsigned IDLE_PCT     = 36;
  localparam int unsigned MAX_PRINTS   = 40;
  // Highest region number a 32-bit pointer can reach.
  localparam logic [PTR_W-1:0] REGION_TOP = {PTR_W{1'b1}} / MAP_ENTRIES;

  // Mode codes outside the defined set; the block must reject them.
  localparam logic [2:0] MODE_UNUSED_5 = 3'd5;
  localparam logic [2:0] MODE_UNUSED_6 = 3'd6;
  localparam logic [2:0] MODE_UNUSED_7 = 3'd7;

  typedef struct packed {
    logic [2:0]         mode;
    logic [PTR_W-1:0]   old_pointer;
    logic [PTR_W-1:0]   new_pointer;
    logic [COUNT_W-1:0] reserved_count;
  } alloc_req_t;

  typedef struct packed {
    status_t          status;
    logic [PTR_W-1:0] pointer_out;
  } alloc_result_t;

  // One row of the directed table: the request, and a hand-written result
  // where it is obvious, otherwise the predictor decides.
  typedef struct {
    alloc_req_t    stim;
    bit            typed;
    alloc_result_t want;
  } plan_row_t;

  logic clk;
  logic rst;

  cbpa_req_if req ();
  cbpa_rsp_if rsp ();

  checked_block_pointer_allocator_unit #(
    .MAP_ENTRIES(MAP_ENTRIES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  // Predictor state: mirror of the allocation bitmap.
  bit alloc_bits [MAP_ENTRIES];
  // Results the block still owes us, oldest first.
  alloc_result_t expected_results [$];
  // Pointer locations the random part works on, like inode block slots.
  logic [PTR_W-1:0] slot_ptr [SLOTS];
  plan_row_t directed_plan [0:24];

  int unsigned error_count = 0;
  bit calm = 1'b0;   // set during the stretch with no idling on either side

  always #6 clk = ~clk;

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTS) $display("%0t ns mismatch: %s", $time, msg);
  endtask

  // Map update and result for one accepted request.
  function automatic alloc_result_t predict_request(input alloc_req_t it);
    alloc_result_t res;
    logic          legal;
    int unsigned   fill;
    res.status      = STATUS_OK;
    res.pointer_out = it.old_pointer;
    legal           = 1'b0;
    case (it.mode)
      MODE_ALLOCATE: begin
        legal = (it.new_pointer != '0) &&
                (it.old_pointer == '0 || it.old_pointer == it.new_pointer);
      end
      MODE_DEALLOCATE: begin
        legal = (it.new_pointer == '0) && (it.old_pointer != '0);
      end
      MODE_REPLACE: begin
        legal = (it.new_pointer != '0) && (it.old_pointer != '0) &&
                (it.old_pointer / MAP_ENTRIES == it.new_pointer / MAP_ENTRIES);
      end
      MODE_NULLIFY: begin
        res.pointer_out = '0;
        return res;
      end
      MODE_INIT: begin
        fill = (it.reserved_count > MAP_ENTRIES) ? MAP_ENTRIES : it.reserved_count;
        for (int unsigned i = 0; i < MAP_ENTRIES; i++) alloc_bits[i] = (i < fill);
        res.pointer_out = '0;
        return res;
      end
      default: legal = 1'b0;
    endcase
    if (!legal) begin
      res.status = STATUS_INVALID;
    end else begin
      // allocate and replace claim the target first; a set bit means taken
      if (it.mode != MODE_DEALLOCATE) begin
        if (alloc_bits[it.new_pointer % MAP_ENTRIES]) res.status = STATUS_TAKEN;
        else alloc_bits[it.new_pointer % MAP_ENTRIES] = 1'b1;
      end
      if (res.status == STATUS_OK) begin
        if (it.mode != MODE_ALLOCATE) alloc_bits[it.old_pointer % MAP_ENTRIES] = 1'b0;
        res.pointer_out = it.new_pointer;
      end
    end
    return res;
  endfunction

  function automatic logic [PTR_W-1:0] pick_region();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return 1;
      2: return REGION_TOP;
      default: return $urandom_range(0, REGION_TOP);
    endcase
  endfunction

  // Block indexes cluster at both ends of the map so collisions are common.
  function automatic logic [PTR_W-1:0] pick_pointer(input logic [PTR_W-1:0] region);
    int unsigned      sel;
    logic [PTR_W-1:0] idx;
    sel = $urandom_range(0, 99);
    if (sel < 60) idx = $urandom_range(0, 47);
    else if (sel < 75) idx = $urandom_range(MAP_ENTRIES - 56, MAP_ENTRIES - 1);
    else idx = $urandom_range(0, MAP_ENTRIES - 1);
    return region * MAP_ENTRIES + idx;
  endfunction

  // Mostly well-formed updates of a slot's pointer; some noise and corrupted beats.
  task automatic make_request(output alloc_req_t it, output int slot);
    int unsigned      roll;
    int unsigned      s;
    logic [PTR_W-1:0] cur;
    roll = $urandom_range(0, 99);
    s    = $urandom_range(0, SLOTS - 1);
    cur  = slot_ptr[s];
    slot = s;
    it.reserved_count = COUNT_W'($urandom);
    it.old_pointer    = cur;
    it.new_pointer    = '0;
    if (roll < 8) begin
      it.mode        = 3'($urandom);
      it.old_pointer = $urandom;
      it.new_pointer = $urandom;
      slot           = -1;
    end else if (roll < 10) begin
      // full-range count now and then, else a short reserved run
      it.mode = MODE_INIT;
      if ($urandom_range(0, 3) == 0) it.reserved_count = COUNT_W'($urandom);
      else it.reserved_count = COUNT_W'($urandom_range(0, 64));
      slot = -1;
    end else if (roll < 13) begin
      it.mode        = MODE_NULLIFY;
      it.new_pointer = $urandom;
    end else if (cur == '0) begin
      it.mode        = MODE_ALLOCATE;
      it.new_pointer = pick_pointer(pick_region());
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          it.mode        = MODE_ALLOCATE;
          it.new_pointer = $urandom_range(0, 1) ? cur : pick_pointer(pick_region());
        end
        1: it.mode = MODE_DEALLOCATE;
        default: begin
          it.mode        = MODE_REPLACE;
          it.new_pointer = pick_pointer(cur / MAP_ENTRIES);
        end
      endcase
      // a few corrupted requests: one flipped bit in the new pointer
      if ($urandom_range(0, 99) < 8) it.new_pointer ^= PTR_W'(1) << $urandom_range(0, PTR_W - 1);
    end
  endtask

  // Present one beat on req and hold it until taken. Inputs move at the falling
  // edge only; acceptance is judged on the values seen at the rising edge.
  task automatic push_request(input alloc_req_t it, input bit typed,
                              input alloc_result_t want, input int slot);
    alloc_result_t res;
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid          <= 1'b1;
    req.mode           <= it.mode;
    req.old_pointer    <= it.old_pointer;
    req.new_pointer    <= it.new_pointer;
    req.reserved_count <= it.reserved_count;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    res = predict_request(it);
    expected_results.push_back(typed ? want : res);
    // keep the slot in step with what the block will hand back
    if (slot >= 0) slot_ptr[slot] = res.pointer_out;
  endtask

  // Response side: random back-pressure except during the calm stretch.
  initial rsp.ready = 1'b0;
  always @(negedge clk) rsp.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);

  // Compare every response beat against the oldest expectation.
  always @(posedge clk) begin
    alloc_result_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("response beat with none expected: status %0d ptr %h",
                                  rsp.status, rsp.pointer_out));
      end else begin
        want = expected_results.pop_front();
        if (rsp.status !== want.status)
          report_mismatch($sformatf("status %0d, wanted %0d", rsp.status, want.status));
        if (rsp.pointer_out !== want.pointer_out)
          report_mismatch($sformatf("pointer_out %h, wanted %h",
                                    rsp.pointer_out, want.pointer_out));
      end
    end
  end

  // Watchdog: the slowest legal run is far below this.
  initial begin
    #20_000_000;
    $display("checked_block_pointer_allocator_unit_tb: done, errors");
    $finish;
  end

  initial begin
    alloc_req_t it;
    int         slot;
    clk                = 1'b0;
    rst                = 1'b1;
    req.valid          = 1'b0;
    req.mode           = MODE_NULLIFY;
    req.old_pointer    = '0;
    req.new_pointer    = '0;
    req.reserved_count = '0;
    foreach (slot_ptr[i]) slot_ptr[i] = '0;

    // Map starts clear; typed results below follow from that.
    directed_plan = '{
      // allocate: zero target, fresh block, same block again, mismatched old, top block
      '{'{MODE_ALLOCATE, 32'h0, 32'h0, 13'd0}, 1'b1, '{STATUS_INVALID, 32'h0}},
      '{'{MODE_ALLOCATE, 32'h0, 32'h1, 13'd0}, 1'b1, '{STATUS_OK, 32'h1}},
      '{'{MODE_ALLOCATE, 32'h1, 32'h1, 13'd0}, 1'b1, '{STATUS_TAKEN, 32'h1}},
      '{'{MODE_ALLOCATE, 32'h5, 32'h7, 13'd0}, 1'b1, '{STATUS_INVALID, 32'h5}},
      '{'{MODE_ALLOCATE, 32'h0, 32'hFFFF_FFFF, 13'd0}, 1'b1, '{STATUS_OK, 32'hFFFF_FFFF}},
      // replace within the top region, onto itself, across regions, from none
      '{'{MODE_REPLACE, 32'hFFFF_FFFF, 32'hFFFF_F000, 13'd0}, 1'b0, '{STATUS_OK, 32'h0}},
      '{'{MODE_REPLACE, 32'hFFFF_F000, 32'hFFFF_F000, 13'd0}, 1'b1,
        '{STATUS_TAKEN, 32'hFFFF_F000}},
      '{'{MODE_REPLACE, 32'h1, 32'h1001, 13'd0}, 1'b1, '{STATUS_INVALID, 32'h1}},
      '{'{MODE_REPLACE, 32'h0, 32'h2, 13'd0}, 1'b1, '{STATUS_INVALID, 32'h0}},
      // deallocate, then again on the now-free block (no error), then bad forms
      '{'{MODE_DEALLOCATE, 32'h1, 32'h0, 13'd0}, 1'b1, '{STATUS_OK, 32'h0}},
      '{'{MODE_DEALLOCATE, 32'h1, 32'h0, 13'd0}, 1'b1, '{STATUS_OK, 32'h0}},
      '{'{MODE_DEALLOCATE, 32'h0, 32'h0, 13'd0}, 1'b1, '{STATUS_INVALID, 32'h0}},
      '{'{MODE_DEALLOCATE, 32'h3, 32'h3, 13'd0}, 1'b1, '{STATUS_INVALID, 32'h3}},
      '{'{MODE_NULLIFY, 32'hDEAD_BEEF, 32'h1234_5678, 13'h1FFF}, 1'b1, '{STATUS_OK, 32'h0}},
      // undefined mode codes are rejected and leave the map alone
      '{'{MODE_UNUSED_5, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 13'd0}, 1'b1,
        '{STATUS_INVALID, 32'hA5A5_A5A5}},
      '{'{MODE_UNUSED_6, 32'hFFFF_FFFF, 32'h1, 13'd0}, 1'b1,
        '{STATUS_INVALID, 32'hFFFF_FFFF}},
      '{'{MODE_UNUSED_7, 32'h10, 32'h0, 13'd0}, 1'b1, '{STATUS_INVALID, 32'h10}},
      // init: empty, exactly full, over-range count saturating, then one entry
      '{'{MODE_INIT, 32'h77, 32'h99, 13'd0}, 1'b1, '{STATUS_OK, 32'h0}},
      '{'{MODE_ALLOCATE, 32'h0, 32'h1, 13'd0}, 1'b0, '{STATUS_OK, 32'h0}},
      '{'{MODE_INIT, 32'h0, 32'h0, 13'd4096}, 1'b1, '{STATUS_OK, 32'h0}},
      '{'{MODE_ALLOCATE, 32'h0, 32'h8000_0FFF, 13'd0}, 1'b1, '{STATUS_TAKEN, 32'h0}},
      '{'{MODE_INIT, 32'h0, 32'h0, 13'h1FFF}, 1'b1, '{STATUS_OK, 32'h0}},
      '{'{MODE_DEALLOCATE, 32'h800, 32'h0, 13'd0}, 1'b1, '{STATUS_OK, 32'h0}},
      '{'{MODE_ALLOCATE, 32'h0, 32'h1234_5800, 13'd0}, 1'b0, '{STATUS_OK, 32'h0}},
      '{'{MODE_INIT, 32'h0, 32'h0, 13'd1}, 1'b1, '{STATUS_OK, 32'h0}}
    };

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // The block sweeps its map after reset; push_request simply waits on ready.
    foreach (directed_plan[i])
      push_request(directed_plan[i].stim, directed_plan[i].typed, directed_plan[i].want, -1);

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= 250 && n < 400);
      make_request(it, slot);
      push_request(it, 1'b0, '0, slot);
    end
    calm = 1'b0;
    @(negedge clk);
    req.valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    // catch any stray beat after the last expected one
    repeat (20) @(posedge clk);

    if (error_count == 0) begin
      $display("checked_block_pointer_allocator_unit_tb: done, clean");
    end else begin
      $display("checked_block_pointer_allocator_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/cbpa_pkg.sv
rtl/core/cbpa_if.sv
rtl/core/cbpa_map.sv
rtl/core/checked_block_pointer_allocator_unit.sv
rtl/core/cbpa_checker.sv
sim/checked_block_pointer_allocator_unit_tb.sv
